// File: src/sia_pkg.sv
// Shared types, codes and defaults for the shift/insert array.
package sia_pkg;

	// Field widths of the words on the channels
	localparam int unsigned OP_W     = 3;
	localparam int unsigned INDEX_W  = 7;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 7;

	// Defaults for the top-level parameters
	localparam int unsigned DEPTH_DEF      = 64;
	localparam int unsigned ELEM_WIDTH_DEF = 32;

	typedef enum logic [OP_W-1:0] {
		OP_READ   = 3'd0,
		OP_WRITE  = 3'd1,
		OP_INSERT = 3'd2,
		OP_REMOVE = 3'd3,
		OP_APPEND = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Command broadcast to every cell of the row
	typedef enum logic [1:0] {
		CMD_HOLD  = 2'd0,
		CMD_SET   = 2'd1,
		CMD_SHUP  = 2'd2,
		CMD_SHDN  = 2'd3
	} cell_cmd_t;

endpackage

// File: src/sia_if.sv
// Valid/ready channel interfaces for request and response words.
interface sia_req_if;
	import sia_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic [INDEX_W-1:0]        index;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output op, output index, output value, input ready);
	modport sink   (input valid, input op, input index, input value, output ready);
endinterface

interface sia_rsp_if;
	import sia_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] read_value;
	logic [STATUS_W-1:0]       status;
	logic [COUNT_W-1:0]        count;

	modport source (output valid, output read_value, output status, output count,
		input ready);
	modport sink   (input valid, input read_value, input status, input count,
		output ready);
endinterface

// File: src/sia_cell.sv
// One storage cell of the row: holds an element, loads, or takes a neighbour's.
module sia_cell #(
	parameter int unsigned ELEM_WIDTH = 32,
	parameter int unsigned POS_W      = 7,
	parameter int unsigned SLOT       = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sia_pkg::cell_cmd_t      cmd,
	input  logic [POS_W-1:0]        pos,
	input  logic [ELEM_WIDTH-1:0]   wr_data,
	input  logic [ELEM_WIDTH-1:0]   prev_data,
	input  logic [ELEM_WIDTH-1:0]   next_data,
	output logic [ELEM_WIDTH-1:0]   data,
	output logic [ELEM_WIDTH-1:0]   rd_data
);
	import sia_pkg::*;

	localparam logic [POS_W-1:0] MY_POS = POS_W'(SLOT);

	logic                  hit;
	logic                  above;
	logic [ELEM_WIDTH-1:0] data_q;

	assign hit   = (pos == MY_POS);
	assign above = (pos < MY_POS);

	// element register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			case (cmd)
				CMD_SET: begin
					if (hit) data_q <= wr_data;
				end
				CMD_SHUP: begin
					if (hit) data_q <= wr_data;
					else if (above) data_q <= prev_data;
				end
				CMD_SHDN: begin
					if (hit || above) data_q <= next_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign data    = data_q;
	// gated read tap, ORed across the row
	assign rd_data = hit ? data_q : '0;

endmodule

// File: src/shift_insert_array_unit.sv
// Top level: ordered list engine built from a row of element cells.
// An ordered store of up to DEPTH signed elements of ELEM_WIDTH bits with a live count.
// Each request word carries one operation (read, write, insert at index, remove at
// index, append) and yields exactly one response word with the read data, a status
// (ok, index out of range, store full) and the count after the operation. Every
// operation is done on its accepting edge: all cells of the row load their new contents
// in parallel on that edge, so a request can be taken every cycle while responses are
// taken, and the response appears in the output register on the following cycle. A new
// request is taken while the previous response waits, as long as that one is taken too.
// No start-up pass is needed after reset; the store reads as empty at once.
module shift_insert_array_unit #(
	parameter int unsigned DEPTH      = sia_pkg::DEPTH_DEF,
	parameter int unsigned ELEM_WIDTH = sia_pkg::ELEM_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sia_req_if.sink      req,
	sia_rsp_if.source    rsp
);
	import sia_pkg::*;

	localparam int unsigned CW    = $clog2(DEPTH + 1);
	localparam int unsigned POS_W = (CW > INDEX_W) ? CW : INDEX_W;

	logic [CW-1:0]          count_q;
	logic [CW-1:0]          count_nxt;
	logic [POS_W-1:0]       idx_ext;
	logic [POS_W-1:0]       cnt_ext;
	logic [POS_W-1:0]       pos;
	logic                   accept;
	logic                   full;
	cell_cmd_t              cmd;
	status_t                status;
	logic                   rd_ok;
	logic [ELEM_WIDTH-1:0]  wr_data;
	logic [ELEM_WIDTH-1:0]  rd_mux;
	logic [VALUE_W-1:0]     rd_ext;

	logic [ELEM_WIDTH-1:0]  cell_data [DEPTH];
	logic [ELEM_WIDTH-1:0]  cell_rd   [DEPTH];

	logic                   rsp_valid_q;
	logic [VALUE_W-1:0]     rsp_value_q;
	status_t                rsp_status_q;
	logic [COUNT_W-1:0]     rsp_count_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign idx_ext = POS_W'(req.index);
	assign cnt_ext = POS_W'(count_q);
	assign full    = (count_q == CW'(DEPTH));

	// element width conversion on write and read
	generate
		if (ELEM_WIDTH >= VALUE_W) begin : g_wide
			assign wr_data = ELEM_WIDTH'(signed'(req.value));
			assign rd_ext  = rd_mux[VALUE_W-1:0];
		end else begin : g_narrow
			assign wr_data = req.value[ELEM_WIDTH-1:0];
			assign rd_ext  = VALUE_W'(signed'(rd_mux));
		end
	endgenerate

	// decode operation into a row command and the response status
	always_comb begin
		cmd       = CMD_HOLD;
		status    = ST_OK;
		rd_ok     = 1'b0;
		pos       = idx_ext;
		count_nxt = count_q;
		case (op_t'(req.op))
			OP_READ: begin
				if (idx_ext < cnt_ext) rd_ok = 1'b1;
				else status = ST_RANGE;
			end
			OP_WRITE: begin
				if (idx_ext < cnt_ext) cmd = CMD_SET;
				else status = ST_RANGE;
			end
			OP_INSERT: begin
				if (idx_ext > cnt_ext) status = ST_RANGE;
				else if (full) status = ST_FULL;
				else begin
					cmd       = CMD_SHUP;
					count_nxt = count_q + CW'(1);
				end
			end
			OP_REMOVE: begin
				if (idx_ext < cnt_ext) begin
					cmd       = CMD_SHDN;
					count_nxt = count_q - CW'(1);
				end else begin
					status = ST_RANGE;
				end
			end
			OP_APPEND: begin
				pos = cnt_ext;
				if (full) status = ST_FULL;
				else begin
					cmd       = CMD_SHUP;
					count_nxt = count_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
		if (!accept) cmd = CMD_HOLD;
	end

	// the row of cells, each linked to its neighbours
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [ELEM_WIDTH-1:0] prev_d;
			logic [ELEM_WIDTH-1:0] next_d;
			if (gi == 0) begin : g_first
				assign prev_d = '0;
			end else begin : g_mid_lo
				assign prev_d = cell_data[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign next_d = '0;
			end else begin : g_mid_hi
				assign next_d = cell_data[gi+1];
			end
			sia_cell #(
				.ELEM_WIDTH (ELEM_WIDTH),
				.POS_W      (POS_W),
				.SLOT       (gi)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.pos       (pos),
				.wr_data   (wr_data),
				.prev_data (prev_d),
				.next_data (next_d),
				.data      (cell_data[gi]),
				.rd_data   (cell_rd[gi])
			);
		end
	endgenerate

	// read select: at most one cell drives its tap
	always_comb begin
		rd_mux = '0;
		for (int i = 0; i < DEPTH; i++) rd_mux = rd_mux | cell_rd[i];
	end

	// live count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_value_q  <= rd_ok ? rd_ext : '0;
			rsp_status_q <= status;
			rsp_count_q  <= COUNT_W'(count_nxt);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.count      = rsp_count_q;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the shift/insert array list engine.
`timescale 1ns / 1ps

module tb_top;
	import sia_pkg::*;

	localparam int unsigned DEPTH       = DEPTH_DEF;
	localparam int unsigned WORDS_TOTAL = 1400;
	localparam int unsigned CALM_TAIL   = 150;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// Op codes that the block must treat as no-ops
	localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	// Random episode flavours
	typedef enum int {
		EP_GROW,
		EP_SHRINK,
		EP_MIXED,
		EP_NOISE
	} episode_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		status_t                   status;
		logic [COUNT_W-1:0]        count;
	} list_rsp_t;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic [INDEX_W-1:0]        index;
		logic signed [VALUE_W-1:0] value;
		bit                        typed;
		list_rsp_t                 want;
	} dir_row_t;

	localparam list_rsp_t NO_RSP = '{32'sd0, ST_OK, 7'd0};
	localparam int unsigned DIR_ROWS = 25;

	logic clk;
	logic arst_n;

	sia_req_if req ();
	sia_rsp_if rsp ();

	shift_insert_array_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Shadow copy of the list
	logic signed [VALUE_W-1:0] list_mem [DEPTH];
	int                        list_len;

	list_rsp_t pending_rsp [$];
	int        fails;
	int        words_sent;
	int        cycles;
	int        op_tally [8];
	int        status_tally [4];
	int        peak_len;
	bit        calm;
	bit        gaps_on;
	bit        stalls_on;

	// Directed words: empty-list errors, extremes, spare codes, edge indexes
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{OP_READ,    7'd0,   32'sd0,        1'b1, '{32'sd0,        ST_RANGE, 7'd0}},
		'{OP_WRITE,   7'd0,   32'h0000_1234, 1'b1, '{32'sd0,        ST_RANGE, 7'd0}},
		'{OP_REMOVE,  7'd0,   32'sd0,        1'b1, '{32'sd0,        ST_RANGE, 7'd0}},
		'{OP_INSERT,  7'd1,   32'sd5,        1'b1, '{32'sd0,        ST_RANGE, 7'd0}},
		'{OP_INSERT,  7'd127, 32'sd5,        1'b1, '{32'sd0,        ST_RANGE, 7'd0}},
		'{OP_SPARE_5, 7'd0,   32'hFFFF_FFFF, 1'b1, '{32'sd0,        ST_OK,    7'd0}},
		'{OP_APPEND,  7'd127, 32'h7FFF_FFFF, 1'b1, '{32'sd0,        ST_OK,    7'd1}},
		'{OP_APPEND,  7'd0,   32'h8000_0000, 1'b1, '{32'sd0,        ST_OK,    7'd2}},
		'{OP_READ,    7'd0,   32'sd0,        1'b1, '{32'h7FFF_FFFF, ST_OK,    7'd2}},
		'{OP_READ,    7'd1,   32'sd0,        1'b1, '{32'h8000_0000, ST_OK,    7'd2}},
		'{OP_READ,    7'd2,   32'sd0,        1'b1, '{32'sd0,        ST_RANGE, 7'd2}},
		'{OP_INSERT,  7'd0,   32'hFFFF_FFFF, 1'b0, NO_RSP},
		'{OP_INSERT,  7'd3,   32'sd0,        1'b0, NO_RSP},
		'{OP_INSERT,  7'd2,   32'h5A5A_5A5A, 1'b0, NO_RSP},
		'{OP_SPARE_6, 7'd127, 32'h7FFF_FFFF, 1'b0, NO_RSP},
		'{OP_SPARE_7, 7'd64,  32'h8000_0000, 1'b0, NO_RSP},
		'{OP_WRITE,   7'd4,   32'hDEAD_BEEF, 1'b0, NO_RSP},
		'{OP_WRITE,   7'd5,   32'h1111_1111, 1'b0, NO_RSP},
		'{OP_READ,    7'd64,  32'sd0,        1'b0, NO_RSP},
		'{OP_READ,    7'd4,   32'sd0,        1'b0, NO_RSP},
		'{OP_REMOVE,  7'd0,   32'sd0,        1'b0, NO_RSP},
		'{OP_REMOVE,  7'd3,   32'sd0,        1'b0, NO_RSP},
		'{OP_REMOVE,  7'd5,   32'sd0,        1'b0, NO_RSP},
		'{OP_READ,    7'd0,   32'sd0,        1'b0, NO_RSP},
		'{OP_READ,    7'd2,   32'sd0,        1'b0, NO_RSP}
	};

	// Apply one operation to the shadow list and return the response it gives
	function automatic list_rsp_t apply_list_op(input logic [OP_W-1:0] op,
		input logic [INDEX_W-1:0] idx, input logic signed [VALUE_W-1:0] val);
		list_rsp_t r;
		int        pos;
		r = NO_RSP;
		case (op)
			OP_READ: begin
				if (idx < list_len) r.read_value = list_mem[idx];
				else r.status = ST_RANGE;
			end
			OP_WRITE: begin
				if (idx < list_len) list_mem[idx] = val;
				else r.status = ST_RANGE;
			end
			OP_INSERT, OP_APPEND: begin
				pos = (op == OP_APPEND) ? list_len : int'(idx);
				// index is checked before fullness
				if (pos > list_len) r.status = ST_RANGE;
				else if (list_len >= DEPTH) r.status = ST_FULL;
				else begin
					for (int k = list_len; k > pos; k--) list_mem[k] = list_mem[k-1];
					list_mem[pos] = val;
					list_len++;
				end
			end
			OP_REMOVE: begin
				if (idx < list_len) begin
					for (int k = idx; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
					list_mem[list_len-1] = '0;
					list_len--;
				end else begin
					r.status = ST_RANGE;
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(list_len);
		op_tally[op]++;
		status_tally[r.status]++;
		if (list_len > peak_len) peak_len = list_len;
		return r;
	endfunction

	// Present one word and hold it until taken; queue its expected response
	task automatic send_word(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
		input logic signed [VALUE_W-1:0] val, input bit typed, input list_rsp_t typed_rsp);
		list_rsp_t model_rsp;
		req.valid <= 1'b1;
		req.op    <= op;
		req.index <= idx;
		req.value <= val;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		model_rsp = apply_list_op(op, idx, val);
		pending_rsp.push_back(typed ? typed_rsp : model_rsp);
		words_sent++;
	endtask

	// Occasional burst of idle cycles on the request side
	task automatic maybe_idle();
		if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Stop sending until every outstanding response is back
	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	task automatic note_mismatch(input string what, input list_rsp_t want,
		input list_rsp_t got);
		fails++;
		if (fails <= 10)
			$display("[%0t] %s: want rd=%0d st=%0d cnt=%0d, got rd=%0d st=%0d cnt=%0d",
				$time, what, want.read_value, want.status, want.count,
				got.read_value, got.status, got.count);
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_op(input episode_t ep);
		int r;
		r = $urandom_range(0, 99);
		case (ep)
			EP_GROW:
				return (r < 40) ? OP_APPEND : (r < 75) ? OP_INSERT : (r < 85) ? OP_READ :
					(r < 92) ? OP_WRITE : OP_REMOVE;
			EP_SHRINK:
				return (r < 40) ? OP_REMOVE : (r < 60) ? OP_READ : (r < 75) ? OP_WRITE :
					(r < 88) ? OP_INSERT : OP_APPEND;
			EP_MIXED:
				return (r < 20) ? OP_READ : (r < 40) ? OP_WRITE : (r < 60) ? OP_INSERT :
					(r < 80) ? OP_REMOVE : OP_APPEND;
			default:
				return OP_W'($urandom_range(0, 7));
		endcase
	endfunction

	// Mostly legal positions, some from 0 to DEPTH, a few anywhere; all anywhere in noise episodes
	function automatic logic [INDEX_W-1:0] pick_index(input logic [OP_W-1:0] op,
		input episode_t ep);
		int hi;
		int r;
		hi = (op == OP_INSERT) ? list_len : list_len - 1;
		r  = $urandom_range(0, 99);
		if (ep == EP_NOISE || r >= 92) return INDEX_W'($urandom_range(0, 127));
		if (r < 80 && hi >= 0) return INDEX_W'($urandom_range(0, hi));
		return INDEX_W'($urandom_range(0, DEPTH));
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("shift_insert_array_unit: mismatch");
			$finish;
		end
	end

	// Response side back-pressure
	initial begin : drive_ready
		int hold;
		hold = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				rsp.ready <= 1'b0;
				hold--;
			end else if (stalls_on && !calm && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				hold = $urandom_range(1, 8) - 1;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Compare each response word with the oldest expectation
	always @(posedge clk) begin : check_rsp
		list_rsp_t got;
		list_rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.read_value = rsp.read_value;
			got.status     = status_t'(rsp.status);
			got.count      = rsp.count;
			if (pending_rsp.size() == 0) begin
				note_mismatch("unexpected response", NO_RSP, got);
			end else begin
				want = pending_rsp.pop_front();
				if (got.read_value !== want.read_value || got.status !== want.status ||
					got.count !== want.count)
					note_mismatch("response mismatch", want, got);
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		episode_t ep;
		int       ep_len;
		int       ep_num;
		logic [OP_W-1:0] op;
		fails      = 0;
		words_sent = 0;
		cycles     = 0;
		peak_len   = 0;
		list_len   = 0;
		calm       = 1'b0;
		gaps_on    = 1'b1;
		stalls_on  = 1'b1;
		foreach (list_mem[i]) list_mem[i] = '0;
		foreach (op_tally[i]) op_tally[i] = 0;
		foreach (status_tally[i]) status_tally[i] = 0;
		arst_n    <= 1'b0;
		req.valid <= 1'b0;
		req.op    <= OP_READ;
		req.index <= '0;
		req.value <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_tab[i]) begin
			send_word(dir_tab[i].op, dir_tab[i].index, dir_tab[i].value,
				dir_tab[i].typed, dir_tab[i].want);
			maybe_idle();
		end
		drain();

		// random episodes; the first one grows the list
		ep_num = 0;
		while (words_sent < WORDS_TOTAL) begin
			ep        = (ep_num == 0) ? EP_GROW : episode_t'($urandom_range(0, 3));
			ep_len    = (ep_num == 0) ? 120 : $urandom_range(30, 120);
			gaps_on   = $urandom_range(0, 2) != 0;
			stalls_on = $urandom_range(0, 2) != 0;
			for (int k = 0; k < ep_len && words_sent < WORDS_TOTAL; k++) begin
				calm = words_sent >= WORDS_TOTAL - CALM_TAIL;
				op   = pick_op(ep);
				send_word(op, pick_index(op, ep), pick_value(), 1'b0, NO_RSP);
				maybe_idle();
			end
			if (!calm && (ep_num == 0 || $urandom_range(0, 2) == 0)) drain();
			ep_num++;
		end

		drain();
		repeat (8) @(posedge clk);

		$display("Sent %0d words: %0d rd, %0d wr, %0d ins, %0d rm, %0d app, %0d spare",
			words_sent, op_tally[OP_READ], op_tally[OP_WRITE], op_tally[OP_INSERT],
			op_tally[OP_REMOVE], op_tally[OP_APPEND],
			op_tally[OP_SPARE_5] + op_tally[OP_SPARE_6] + op_tally[OP_SPARE_7]);
		$display("Status ok/range/full = %0d/%0d/%0d, longest list %0d of %0d, %0d bad words",
			status_tally[ST_OK], status_tally[ST_RANGE], status_tally[ST_FULL],
			peak_len, DEPTH, fails);
		if (fails == 0 && pending_rsp.size() == 0) begin
			$display("shift_insert_array_unit: match");
		end else begin
			$display("shift_insert_array_unit: mismatch");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/sia_pkg.sv
src/sia_if.sv
src/sia_cell.sv
src/shift_insert_array_unit.sv
tb/sv/tb_top.sv
